// File: hw/rtl/buddy_page_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared wrappers for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Check that is masked while reset is applied.
`define BPA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("buddy allocator check failed");

// Check that also holds while reset is applied.
`define BPA_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("buddy allocator reset check failed");

`endif

// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Defaults, field widths and codes of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int DEF_PAGE_COUNT = 1024;
	localparam int DEF_MAX_ORDER  = 10;
	localparam int DEF_PAGE_SHIFT = 12;

	localparam int ORDER_W  = 4;
	localparam int ADDR_W   = 32;
	localparam int STAT_W   = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [STAT_W-1:0] RS_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] RS_BAD_ORDER = 2'd1;
	localparam logic [STAT_W-1:0] RS_NO_MEM    = 2'd2;

	typedef enum logic [1:0] {
		PG_FREE   = 2'd0,
		PG_USED   = 2'd1,
		PG_FOLLOW = 2'd2
	} pg_status_t;

	typedef struct packed {
		logic [ORDER_W-1:0] order;
		pg_status_t         status;
	} page_ent_t;

endpackage

// File: hw/rtl/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks from per-order free lists.
// ----------------------------------------------------------------------------
// Usage: an item on the slave stream carries an operation in s_tuser (0 allocate,
// 1 free), the requested order and the address to free. Every item returns one
// item on the master stream with the block address and a status code.
// The user must write the base address register through cfg_we and cfg_wdata
// only while idle; the block itself leaves this unenforced. Items are handled
// one at a time. Page order and status live in one memory, the list links in
// another; both have one read and one write port. The page sweeps of marking
// dominate the latency. After reset the block sweeps the whole page memory to
// build the initial free lists and does not accept items during that sweep.
// A finished item waits in the output register while the master side stalls;
// a new item is taken meanwhile, and its result waits until the output is free.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top #(
	parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
	parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
	parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// request_order [3:0], free_address [35:4], zero fill above
	input  logic [bpa_pkg::S_DATA_W-1:0]  s_tdata,
	// mode [0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// block_address [31:0], status [33:32], zero fill above
	output logic [bpa_pkg::M_DATA_W-1:0]  m_tdata
);
	import bpa_pkg::*;

	localparam int IW = $clog2(PAGE_COUNT);
	localparam int XW = ((IW > MAX_ORDER) ? IW : MAX_ORDER) + 2;
	localparam int LW = (MAX_ORDER + 1 > 1) ? $clog2(MAX_ORDER + 1) : 1;
	localparam int CW = $clog2(PAGE_COUNT + 1);
	localparam int NL = MAX_ORDER + 1;
	localparam logic [XW-1:0] NUM = XW'(PAGE_COUNT);
	localparam logic [ORDER_W-1:0] MAXO = ORDER_W'(MAX_ORDER);
	localparam logic [XW-1:0] TOPSZ = XW'(1) << MAX_ORDER;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SPLIT, S_MK, S_PU_W0, S_PU_W1, S_RM_RD, S_RM_DAT,
		S_RM_W2, S_RM_W3, S_RL_RC, S_RL_DC, S_RL_DB, S_RL_MERGE, S_RL_END, S_FINISH
	} state_t;

	state_t state_q;

	page_ent_t pmem [PAGE_COUNT];
	logic [2*IW-1:0] lmem [PAGE_COUNT];

	logic          pm_we;
	logic [IW-1:0] pm_wa, pm_ra;
	page_ent_t     pm_wd, pm_rd;
	logic          lm_we_n, lm_we_p;
	logic [IW-1:0] lm_wa, lm_ra, lm_wn, lm_wp;
	logic [2*IW-1:0] lm_rd;

	logic [IW-1:0] list_head [NL];
	logic [IW-1:0] list_tail [NL];
	logic [CW-1:0] list_count [NL];

	logic [ADDR_W-1:0]  base_q;
	logic               op_free_q;
	logic [ORDER_W-1:0] req_q, ord_q, lord_q, blk_ord_q;
	logic [IW-1:0]      pf_q, c_q, bud_q, x_q, lp_q, ln_q;
	pg_status_t         cstat_q, mk_hs_q, mk_fs_q;
	logic [XW-1:0]      mk_addr_q, mk_end_q, ip_q, nh_q;
	logic [ORDER_W-1:0] mk_ord_q;
	logic               mk_first_q, mk_last_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [STAT_W-1:0]  res_stat_q;

	logic               in_mode;
	logic [ORDER_W-1:0] in_req;
	logic [ADDR_W-1:0]  in_faddr, in_idx;
	logic               found;
	logic [ORDER_W-1:0] found_ord, init_k, dc_ord, lo;
	logic [XW-1:0]      bud_x, sec_x, init_next, init_prev;
	logic [IW-1:0]      head_sel, tail_sel;
	logic [CW-1:0]      cnt_sel;

	assign in_mode  = s_tuser;
	assign in_req   = s_tdata[ORDER_W-1:0];
	assign in_faddr = s_tdata[ORDER_W+ADDR_W-1:ORDER_W];
	assign in_idx   = (in_faddr - base_q) >> PAGE_SHIFT;
	assign s_tready = (state_q == S_IDLE);

	assign head_sel = list_head[lord_q[LW-1:0]];
	assign tail_sel = list_tail[lord_q[LW-1:0]];
	assign cnt_sel  = list_count[lord_q[LW-1:0]];

	assign dc_ord = (pm_rd.order > MAXO) ? MAXO : pm_rd.order;
	assign bud_x  = XW'(c_q) ^ (XW'(1) << dc_ord);
	assign lo     = ord_q - ORDER_W'(1);
	assign sec_x  = XW'(pf_q) + (XW'(1) << lo);

	assign init_prev = (ip_q >= TOPSZ) ? (ip_q - TOPSZ) : '0;
	assign init_next = (ip_q + (TOPSZ << 1) <= NUM) ? (ip_q + TOPSZ) : '0;

	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if (ORDER_W'(k) >= in_req && list_count[k] != '0) begin
				found     = 1'b1;
				found_ord = ORDER_W'(k);
			end
		end
	end

	always_comb begin
		init_k = '0;
		for (int k = 0; k <= MAX_ORDER; k++) begin
			if ((ip_q & ((XW'(1) << k) - XW'(1))) == '0 && ip_q + (XW'(1) << k) <= NUM) begin
				init_k = ORDER_W'(k);
			end
		end
	end

	always_comb begin
		pm_we   = 1'b0;
		pm_wa   = mk_addr_q[IW-1:0];
		pm_wd   = page_ent_t'{order: mk_ord_q, status: mk_first_q ? mk_hs_q : mk_fs_q};
		pm_ra   = c_q;
		lm_we_n = 1'b0;
		lm_we_p = 1'b0;
		lm_wa   = x_q;
		lm_wn   = '0;
		lm_wp   = '0;
		lm_ra   = x_q;
		unique case (state_q)
			S_INIT: begin
				pm_we   = 1'b1;
				pm_wa   = ip_q[IW-1:0];
				lm_we_n = 1'b1;
				lm_we_p = 1'b1;
				lm_wa   = ip_q[IW-1:0];
				if (ip_q == nh_q) begin
					pm_wd = page_ent_t'{order: init_k, status: PG_FREE};
					if (init_k == MAXO) begin
						lm_wn = init_next[IW-1:0];
						lm_wp = init_prev[IW-1:0];
					end
				end else begin
					pm_wd = page_ent_t'{order: blk_ord_q, status: PG_FOLLOW};
				end
			end
			S_MK: begin
				pm_we = (mk_addr_q < mk_end_q) && (mk_addr_q < NUM);
			end
			S_PU_W0: begin
				if (cnt_sel == '0) begin
					lm_we_n = 1'b1;
					lm_we_p = 1'b1;
				end else begin
					lm_we_n = 1'b1;
					lm_wa   = tail_sel;
					lm_wn   = x_q;
				end
			end
			S_PU_W1: begin
				lm_we_n = 1'b1;
				lm_we_p = 1'b1;
				lm_wp   = tail_sel;
			end
			S_RM_DAT: begin
				if (head_sel != x_q) begin
					lm_we_n = 1'b1;
					lm_wa   = lm_rd[IW-1:0];
					lm_wn   = lm_rd[2*IW-1:IW];
				end
			end
			S_RM_W2: begin
				if (tail_sel != x_q) begin
					lm_we_p = 1'b1;
					lm_wa   = ln_q;
					lm_wp   = lp_q;
				end
			end
			S_RM_W3: begin
				lm_we_n = 1'b1;
				lm_we_p = 1'b1;
			end
			S_RL_DC: begin
				pm_ra = bud_x[IW-1:0];
			end
			S_RL_MERGE: begin
				pm_we = 1'b1;
				if (bud_q > c_q) begin
					pm_wa = c_q;
					pm_wd = page_ent_t'{order: ord_q + ORDER_W'(1), status: cstat_q};
				end else begin
					pm_wa = bud_q;
					pm_wd = page_ent_t'{order: ord_q + ORDER_W'(1), status: PG_FREE};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pmem[pm_wa] <= pm_wd;
		end
		pm_rd <= pmem[pm_ra];
	end

	always_ff @(posedge clk) begin
		if (lm_we_n) begin
			lmem[lm_wa][2*IW-1:IW] <= lm_wn;
		end
		if (lm_we_p) begin
			lmem[lm_wa][IW-1:0] <= lm_wp;
		end
		lm_rd <= lmem[lm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			base_q     <= '0;
			op_free_q  <= 1'b0;
			req_q      <= '0;
			ord_q      <= '0;
			lord_q     <= '0;
			blk_ord_q  <= '0;
			pf_q       <= '0;
			c_q        <= '0;
			bud_q      <= '0;
			x_q        <= '0;
			lp_q       <= '0;
			ln_q       <= '0;
			cstat_q    <= PG_FREE;
			mk_hs_q    <= PG_FREE;
			mk_fs_q    <= PG_FOLLOW;
			mk_addr_q  <= '0;
			mk_end_q   <= '0;
			mk_ord_q   <= '0;
			mk_first_q <= 1'b0;
			mk_last_q  <= 1'b0;
			ip_q       <= '0;
			nh_q       <= '0;
			res_addr_q <= '0;
			res_stat_q <= RS_DONE;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			for (int k = 0; k < NL; k++) begin
				list_head[k]  <= '0;
				list_tail[k]  <= '0;
				list_count[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (m_tvalid && m_tready && state_q != S_FINISH) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (ip_q == nh_q) begin
						nh_q      <= ip_q + (XW'(1) << init_k);
						blk_ord_q <= init_k;
						if (list_count[init_k[LW-1:0]] == '0) begin
							list_head[init_k[LW-1:0]] <= ip_q[IW-1:0];
						end
						list_tail[init_k[LW-1:0]]  <= ip_q[IW-1:0];
						list_count[init_k[LW-1:0]] <= list_count[init_k[LW-1:0]] + CW'(1);
					end
					ip_q <= ip_q + XW'(1);
					if (ip_q == NUM - XW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_free_q  <= in_mode;
						req_q      <= in_req;
						res_addr_q <= '0;
						res_stat_q <= RS_DONE;
						if (!in_mode) begin
							if (in_req > MAXO) begin
								res_stat_q <= RS_BAD_ORDER;
								state_q    <= S_FINISH;
							end else if (!found) begin
								res_stat_q <= RS_NO_MEM;
								state_q    <= S_FINISH;
							end else begin
								pf_q    <= list_head[found_ord[LW-1:0]];
								x_q     <= list_head[found_ord[LW-1:0]];
								ord_q   <= found_ord;
								lord_q  <= found_ord;
								state_q <= S_RM_RD;
							end
						end else if (in_idx >= ADDR_W'(PAGE_COUNT)) begin
							state_q <= S_FINISH;
						end else begin
							c_q     <= in_idx[IW-1:0];
							state_q <= S_RL_RC;
						end
					end
				end
				S_SPLIT: begin
					if (ord_q > req_q) begin
						ord_q <= lo;
						if (sec_x < NUM) begin
							mk_addr_q  <= sec_x;
							mk_end_q   <= sec_x + (XW'(1) << lo);
							mk_ord_q   <= lo;
							mk_hs_q    <= PG_FREE;
							mk_fs_q    <= PG_FOLLOW;
							mk_first_q <= 1'b1;
							mk_last_q  <= 1'b0;
							x_q        <= sec_x[IW-1:0];
							lord_q     <= lo;
							state_q    <= S_MK;
						end
					end else begin
						mk_addr_q  <= XW'(pf_q);
						mk_end_q   <= XW'(pf_q) + (XW'(1) << ord_q);
						mk_ord_q   <= ord_q;
						mk_hs_q    <= PG_USED;
						mk_fs_q    <= PG_USED;
						mk_first_q <= 1'b1;
						mk_last_q  <= 1'b1;
						res_addr_q <= base_q + (ADDR_W'(pf_q) << PAGE_SHIFT);
						state_q    <= S_MK;
					end
				end
				S_MK: begin
					if (mk_addr_q < mk_end_q && mk_addr_q < NUM) begin
						mk_addr_q  <= mk_addr_q + XW'(1);
						mk_first_q <= 1'b0;
					end else if (mk_last_q) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_PU_W0;
					end
				end
				S_PU_W0: begin
					if (cnt_sel == '0) begin
						list_head[lord_q[LW-1:0]]  <= x_q;
						list_tail[lord_q[LW-1:0]]  <= x_q;
						list_count[lord_q[LW-1:0]] <= cnt_sel + CW'(1);
						state_q <= op_free_q ? S_FINISH : S_SPLIT;
					end else begin
						state_q <= S_PU_W1;
					end
				end
				S_PU_W1: begin
					list_tail[lord_q[LW-1:0]]  <= x_q;
					list_count[lord_q[LW-1:0]] <= cnt_sel + CW'(1);
					state_q <= op_free_q ? S_FINISH : S_SPLIT;
				end
				S_RM_RD: begin
					if (cnt_sel == '0) begin
						state_q <= op_free_q ? S_RL_MERGE : S_SPLIT;
					end else begin
						state_q <= S_RM_DAT;
					end
				end
				S_RM_DAT: begin
					lp_q    <= lm_rd[IW-1:0];
					ln_q    <= lm_rd[2*IW-1:IW];
					state_q <= S_RM_W2;
				end
				S_RM_W2: begin
					state_q <= S_RM_W3;
				end
				S_RM_W3: begin
					if (head_sel == x_q) begin
						list_head[lord_q[LW-1:0]] <= ln_q;
					end
					if (tail_sel == x_q) begin
						list_tail[lord_q[LW-1:0]] <= lp_q;
					end
					list_count[lord_q[LW-1:0]] <= cnt_sel - CW'(1);
					state_q <= op_free_q ? S_RL_MERGE : S_SPLIT;
				end
				S_RL_RC: begin
					state_q <= S_RL_DC;
				end
				S_RL_DC: begin
					ord_q   <= dc_ord;
					cstat_q <= pm_rd.status;
					bud_q   <= bud_x[IW-1:0];
					if (dc_ord >= MAXO || bud_x >= NUM) begin
						state_q <= S_RL_END;
					end else begin
						state_q <= S_RL_DB;
					end
				end
				S_RL_DB: begin
					if (pm_rd.status != PG_FREE || pm_rd.order != ord_q) begin
						state_q <= S_RL_END;
					end else begin
						x_q     <= bud_q;
						lord_q  <= ord_q;
						state_q <= S_RM_RD;
					end
				end
				S_RL_MERGE: begin
					if (bud_q < c_q) begin
						c_q <= bud_q;
					end
					state_q <= S_RL_RC;
				end
				S_RL_END: begin
					mk_addr_q  <= XW'(c_q);
					mk_end_q   <= XW'(c_q) + (XW'(1) << ord_q);
					mk_ord_q   <= ord_q;
					mk_hs_q    <= PG_FREE;
					mk_fs_q    <= PG_FOLLOW;
					mk_first_q <= 1'b1;
					mk_last_q  <= 1'b0;
					x_q        <= c_q;
					lord_q     <= ord_q;
					state_q    <= S_MK;
				end
				S_FINISH: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {(M_DATA_W-ADDR_W-STAT_W)'(0), res_stat_q, res_addr_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "buddy_page_allocator_top_assert.svh"

	`BPA_ASSERT(a_init_quiet, (state_q == S_INIT) |-> (!s_tready && !m_tvalid))
	`BPA_ASSERT(a_mark_bound, (state_q == S_MK) |-> (mk_addr_q <= mk_end_q))
	`BPA_ASSERT(a_fail_zero, (m_tvalid && m_tdata[33:32] != RS_DONE) |-> (m_tdata[31:0] == '0))

endmodule

// File: bench/tb_buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free items with random gaps and output stalls, keeps its
// own copy of the page tables and free lists, and compares every result item.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator_top;
	import bpa_pkg::*;

	localparam int NPAGES = DEF_PAGE_COUNT;
	localparam int TOP_ORD = DEF_MAX_ORDER;
	localparam int PSHIFT = DEF_PAGE_SHIFT;
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] stat;
	} alloc_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [M_DATA_W-1:0] m_tdata;

	buddy_page_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	logic [ADDR_W-1:0] base_addr;
	int pg_ord [NPAGES];
	pg_status_t pg_stat [NPAGES];
	int nxt [NPAGES];
	int prv [NPAGES];
	int head_of [TOP_ORD+1];
	int tail_of [TOP_ORD+1];
	int count_of [TOP_ORD+1];

	alloc_result_t pending_results[$];
	int held_pages[$];
	int held_orders[$];
	int errors = 0;
	int n_alloc = 0, n_free = 0, n_bad = 0, n_nomem = 0;
	bit no_idle = 0;

	function automatic void mark_run(int start, int n, int ord, pg_status_t st);
		for (int k = 0; k < n; k++) begin
			if (start + k >= NPAGES)
				break;
			pg_ord[start + k] = ord;
			pg_stat[start + k] = st;
		end
	endfunction

	function automatic void push_tail(int ord, int x);
		if (count_of[ord] == 0) begin
			head_of[ord] = x;
			prv[x] = 0;
		end else begin
			nxt[tail_of[ord]] = x;
			prv[x] = tail_of[ord];
		end
		nxt[x] = 0;
		tail_of[ord] = x;
		count_of[ord]++;
	endfunction

	function automatic void unlink(int ord, int x);
		int p, n;
		if (count_of[ord] == 0)
			return;
		p = prv[x];
		n = nxt[x];
		if (head_of[ord] == x)
			head_of[ord] = n;
		else
			nxt[p] = n;
		if (tail_of[ord] == x)
			tail_of[ord] = p;
		else
			prv[n] = p;
		nxt[x] = 0;
		prv[x] = 0;
		count_of[ord]--;
	endfunction

	function automatic void tables_reset();
		int p, k;
		base_addr = '0;
		for (int i = 0; i < NPAGES; i++) begin
			pg_ord[i] = 0;
			pg_stat[i] = PG_FREE;
			nxt[i] = 0;
			prv[i] = 0;
		end
		for (int i = 0; i <= TOP_ORD; i++) begin
			head_of[i] = 0;
			tail_of[i] = 0;
			count_of[i] = 0;
		end
		p = 0;
		while (p < NPAGES) begin
			k = TOP_ORD;
			while (k > 0 && ((p & ((1 << k) - 1)) != 0 || p + (1 << k) > NPAGES))
				k--;
			pg_ord[p] = k;
			pg_stat[p] = PG_FREE;
			mark_run(p + 1, (1 << k) - 1, k, PG_FOLLOW);
			push_tail(k, p);
			p += 1 << k;
		end
	endfunction

	function automatic void merge_and_release(int c);
		int ord, bud;
		forever begin
			ord = (pg_ord[c] > TOP_ORD) ? TOP_ORD : pg_ord[c];
			if (ord >= TOP_ORD)
				break;
			bud = c ^ (1 << ord);
			if (bud >= NPAGES || pg_stat[bud] != PG_FREE || pg_ord[bud] != ord)
				break;
			unlink(ord, bud);
			if (bud > c) begin
				pg_ord[c] = ord + 1;
			end else begin
				pg_ord[bud] = ord + 1;
				c = bud;
			end
		end
		ord = (pg_ord[c] > TOP_ORD) ? TOP_ORD : pg_ord[c];
		pg_ord[c] = ord;
		pg_stat[c] = PG_FREE;
		mark_run(c + 1, (1 << ord) - 1, ord, PG_FOLLOW);
		push_tail(ord, c);
	endfunction

	function automatic alloc_result_t apply_item(logic mode, logic [ORDER_W-1:0] req,
			logic [ADDR_W-1:0] faddr);
		alloc_result_t r;
		int i, pf, ord, sec;
		logic [ADDR_W-1:0] idx;
		r.addr = '0;
		r.stat = RS_DONE;
		if (mode == MODE_FREE) begin
			n_free++;
			idx = (faddr - base_addr) >> PSHIFT;
			if (idx < NPAGES)
				merge_and_release(int'(idx));
			return r;
		end
		if (req > TOP_ORD) begin
			n_bad++;
			r.stat = RS_BAD_ORDER;
			return r;
		end
		for (i = int'(req); i <= TOP_ORD; i++)
			if (count_of[i] > 0)
				break;
		if (i > TOP_ORD) begin
			n_nomem++;
			r.stat = RS_NO_MEM;
			return r;
		end
		n_alloc++;
		pf = head_of[i];
		unlink(i, pf);
		ord = i;
		while (ord > req) begin
			ord--;
			sec = pf + (1 << ord);
			if (sec < NPAGES) begin
				pg_ord[sec] = ord;
				pg_stat[sec] = PG_FREE;
				mark_run(sec + 1, (1 << ord) - 1, ord, PG_FOLLOW);
				push_tail(ord, sec);
			end
		end
		pg_ord[pf] = ord;
		pg_stat[pf] = PG_USED;
		mark_run(pf + 1, (1 << ord) - 1, ord, PG_USED);
		r.addr = base_addr + (ADDR_W'(pf) << PSHIFT);
		held_pages.push_back(pf);
		held_orders.push_back(ord);
		return r;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(16, 0);
	endfunction

	task automatic send_item(logic mode, logic [ORDER_W-1:0] req, logic [ADDR_W-1:0] faddr);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, faddr, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_item(mode, req, faddr));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_base(logic [ADDR_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_addr = v;
		@(posedge clk);
	endtask

	task automatic free_held(int k);
		send_item(MODE_FREE, 4'($urandom), base_addr + (ADDR_W'(held_pages[k]) << PSHIFT));
		held_pages.delete(k);
		held_orders.delete(k);
	endtask

	task automatic test_whole_region();
		send_item(MODE_ALLOC, 4'd10, '0);
		send_item(MODE_ALLOC, 4'd0, '0);
		free_held(0);
		send_item(MODE_ALLOC, 4'd0, '0);
		send_item(MODE_ALLOC, 4'd0, '0);
		send_item(MODE_ALLOC, 4'd3, '0);
		while (held_pages.size() != 0)
			free_held(held_pages.size() - 1);
	endtask

	task automatic test_bad_orders();
		for (int o = 11; o <= 15; o++)
			send_item(MODE_ALLOC, 4'(o), 32'hFFFF_FFFF);
	endtask

	task automatic test_odd_frees();
		send_item(MODE_FREE, 4'hF, 32'hFFFF_FFFF);
		send_item(MODE_FREE, 4'h0, base_addr + (NPAGES << PSHIFT));
		send_item(MODE_ALLOC, 4'd2, '0);
		send_item(MODE_FREE, 4'h0, base_addr + (ADDR_W'(held_pages[0] + 1) << PSHIFT));
		free_held(0);
		send_item(MODE_FREE, 4'h0, base_addr);
	endtask

	task automatic test_quiet_sender();
		send_item(MODE_ALLOC, 4'd1, '0);
		drain();
		send_item(MODE_ALLOC, 4'd1, '0);
	endtask

	task automatic test_random_mix(int n);
		int pick, o;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(3, 0) == 0);
			pick = $urandom_range(99, 0);
			if (pick < 55 || held_pages.size() == 0) begin
				o = $urandom_range(99, 0);
				if (o < 70)
					o = $urandom_range(2, 0);
				else if (o < 90)
					o = $urandom_range(6, 3);
				else if (o < 97)
					o = $urandom_range(10, 7);
				else
					o = $urandom_range(15, 11);
				send_item(MODE_ALLOC, 4'(o), $urandom);
			end else if (pick < 95) begin
				free_held($urandom_range(held_pages.size() - 1, 0));
			end else begin
				send_item(MODE_FREE, 4'($urandom), $urandom);
			end
		end
		no_idle = 0;
	endtask

	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[31:0] !== e.addr) begin
					$error("block_address expected %h actual %h", e.addr, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[33:32] !== e.stat) begin
					$error("status expected %0d actual %0d", e.stat, m_tdata[33:32]);
					errors++;
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("buddy_page_allocator_top: mismatch");
		$finish;
	end

	initial begin
		tables_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_whole_region();
		test_bad_orders();
		test_odd_frees();
		test_quiet_sender();
		test_random_mix(300);
		write_base(32'hFFFF_F000);
		test_whole_region();
		test_odd_frees();
		test_random_mix(300);
		write_base(32'hFFFF_FFFF);
		test_random_mix(300);
		write_base($urandom);
		test_random_mix(300);
		write_base('0);
		test_odd_frees();
		drain();
		$display("Covered %0d allocations, %0d frees, %0d oversized orders and %0d",
			n_alloc, n_free, n_bad, n_nomem);
		$display("out-of-memory requests over five base address settings.");
		if (errors == 0)
			$display("buddy_page_allocator_top: match");
		else
			$display("buddy_page_allocator_top: mismatch");
		$finish;
	end

endmodule
